[rtl/wsd_pkg.sv]
// Shared types, constants and helpers for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

  // Width of the length accumulator, fixed by the 64-bit extended length field.
  localparam int unsigned AccBits = 64;

  // Largest frame length that the block tracks, in bits (16 to 64).
  localparam int unsigned LENGTH_BITS = 64;

  // Largest representable length; longer lengths saturate to this value.
  localparam logic [AccBits-1:0] LENGTH_MAX = {AccBits{1'b1}} >> (AccBits - LENGTH_BITS);

  // Opcode of a close frame.
  localparam logic [3:0] OPCODE_CLOSE = 4'h8;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Byte counts that close the extended length and mask key phases.
  localparam logic [2:0] LEN16_BYTES    = 3'd2;
  localparam logic [2:0] LEN64_WRAP     = 3'd0;
  localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

  // Parser phases; the spare code behaves as the first header byte phase.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DEAD    = 3'd6
  } phase_e;

  // One result transaction as it travels from the parser to the output register.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic [2:0] reserved_bits;
    logic       closing;
  } result_t;

  // Clamp a received length to the largest value of LENGTH_BITS bits.
  function automatic logic [AccBits-1:0] saturate_len(input logic [AccBits-1:0] value);
    logic over;
    over = 1'b0;
    for (int i = LENGTH_BITS; i < AccBits; i++) begin
      over = over | value[i];
    end
    return over ? LENGTH_MAX : value;
  endfunction

endpackage

`default_nettype wire

[rtl/wsd_input_stage.sv]
// Input register that holds one stream byte until the parser takes it.
`default_nettype none

module wsd_input_stage
  import wsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] stream_byte_i,
  input  wire logic       fire_i,
  output logic            held_valid_o,
  output logic [7:0]      held_byte_o
);

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_byte_q;
  logic       accept;

  // The register stalls the sender only while its byte cannot move on.
  assign in_stall_o = held_valid_q && !fire_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Occupancy follows accepted and consumed transactions.
  always_comb begin
    held_valid_d = held_valid_q;
    if (accept) begin
      held_valid_d = 1'b1;
    end else if (fire_i) begin
      held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
    end
  end

  // The byte itself needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_byte_q <= stream_byte_i;
    end
  end

  assign held_valid_o = held_valid_q;
  assign held_byte_o  = held_byte_q;

endmodule

`default_nettype wire

[rtl/wsd_frame_fsm.sv]
// Frame header parser, length tracker and payload unmasking.
`default_nettype none

module wsd_frame_fsm
  import wsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            has_result_o,
  output result_t         result_o
);

  phase_e             phase_q, phase_d;
  logic [2:0]         count_q, count_d;
  logic               fin_q, fin_d;
  logic [2:0]         rsv_q, rsv_d;
  logic [3:0]         opcode_q, opcode_d;
  logic               masked_q, masked_d;
  logic [AccBits-1:0] length_q, length_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         index_q, index_d;

  // Shared decode of the current byte.
  logic [2:0]         count_inc;
  logic [AccBits-1:0] length_shift;
  logic [AccBits-1:0] length_dec;
  logic [AccBits-1:0] length_known;
  logic               known;
  logic               known_mask;
  logic               enter;
  logic               emit;
  logic               emit_end;
  logic               emit_data;
  logic [7:0]         key_byte;

  assign count_inc    = count_q + 3'd1;
  assign length_shift = {length_q[AccBits-9:0], byte_i};
  assign length_dec   = (length_q != '0) ? length_q - AccBits'(1) : length_q;
  assign key_byte     = masked_q ? key_q[{~index_q, 3'b000} +: 8] : 8'h00;

  // Work out whether this byte completes the length, the key or a frame.
  always_comb begin
    known        = 1'b0;
    known_mask   = masked_q;
    length_known = length_q;
    enter        = 1'b0;
    emit_data    = 1'b0;
    emit_end     = 1'b0;
    case (phase_q)
      PH_DEAD: begin
      end
      PH_HDR1: begin
        known_mask   = byte_i[7];
        length_known = saturate_len({{(AccBits-7){1'b0}}, byte_i[6:0]});
        known        = (byte_i[6:0] != LEN7_EXT16) && (byte_i[6:0] != LEN7_EXT64);
      end
      PH_LEN16: begin
        length_known = saturate_len(length_shift);
        known        = (count_inc == LEN16_BYTES);
      end
      PH_LEN64: begin
        length_known = saturate_len(length_shift);
        known        = (count_inc == LEN64_WRAP);
      end
      PH_MASK: begin
        length_known = length_q;
        enter        = (count_inc >= MASK_KEY_BYTES);
      end
      PH_PAYLOAD: begin
        emit_data = 1'b1;
        emit_end  = (length_dec == '0);
      end
      default: begin
      end
    endcase
    // An unmasked frame goes straight to the payload once its length is known, or ends if it is zero.
    if (known && !known_mask) begin
      enter = 1'b1;
    end
    if (enter && (length_known == '0)) begin
      emit_end = 1'b1;
    end
    emit = emit_data || emit_end;
  end

  // Next state of the parser.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    fin_d    = fin_q;
    rsv_d    = rsv_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    length_d = length_q;
    key_d    = key_q;
    index_d  = index_q;
    case (phase_q)
      PH_DEAD: begin
      end
      PH_HDR1: begin
        masked_d = byte_i[7];
        length_d = '0;
        key_d    = '0;
        count_d  = '0;
        if (byte_i[6:0] == LEN7_EXT16) begin
          phase_d = PH_LEN16;
        end else if (byte_i[6:0] == LEN7_EXT64) begin
          phase_d = PH_LEN64;
        end
      end
      PH_LEN16, PH_LEN64: begin
        length_d = length_shift;
        count_d  = count_inc;
      end
      PH_MASK: begin
        key_d   = {key_q[23:0], byte_i};
        count_d = count_inc;
      end
      PH_PAYLOAD: begin
        index_d  = index_q + 2'd1;
        length_d = length_dec;
      end
      default: begin
        fin_d    = byte_i[7];
        rsv_d    = byte_i[6:4];
        opcode_d = byte_i[3:0];
        phase_d  = PH_HDR1;
        count_d  = '0;
      end
    endcase
    // Length complete: clamp it, then fetch the key or start the payload.
    if (known) begin
      length_d = length_known;
      count_d  = '0;
      if (known_mask) begin
        phase_d = PH_MASK;
      end
    end
    if (enter) begin
      index_d = '0;
      count_d = '0;
      if (length_known != '0) begin
        phase_d = PH_PAYLOAD;
      end
    end
    // A finished frame returns to the header, or stops the stream on close.
    if (emit_end) begin
      phase_d = (opcode_q == OPCODE_CLOSE) ? PH_DEAD : PH_HDR0;
      count_d = '0;
    end
  end

  // Result fields of the current byte.
  always_comb begin
    has_result_o            = emit;
    result_o.payload_byte   = emit_data ? (byte_i ^ key_byte) : 8'h00;
    result_o.byte_valid     = emit_data;
    result_o.frame_end      = emit_end;
    result_o.frame_opcode   = opcode_q;
    result_o.final_fragment = fin_q;
    result_o.reserved_bits  = rsv_q;
    result_o.closing        = emit_end && (opcode_q == OPCODE_CLOSE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      count_q  <= '0;
      fin_q    <= 1'b0;
      rsv_q    <= '0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      length_q <= '0;
      key_q    <= '0;
      index_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      fin_q    <= fin_d;
      rsv_q    <= rsv_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      length_q <= length_d;
      key_q    <= key_d;
      index_q  <= index_d;
    end
  end

endmodule

`default_nettype wire

[rtl/wsd_output_stage.sv]
// Result register that presents one result transaction to the receiver.
`default_nettype none

module wsd_output_stage
  import wsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // The register can take a new result when empty or when it is being taken.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer_unit.sv]
// Top level of the WebSocket frame deframer.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------------------
//   input   | in        | in_valid_i, in_stall_o | stream_byte_i
//   output  | out       | out_valid_o,out_stall_i| payload_byte_o, byte_valid_o,
//           |           |                        | frame_end_o, frame_opcode_o,
//           |           |                        | final_fragment_o, reserved_bits_o,
//           |           |                        | closing_o
//
// One byte is accepted per cycle unless the sender is stalled. The parser step
// between the input and result registers sets the rate and includes the 64-bit
// length decrement of the payload phase. Reset clears all parser state and the
// valid flags of both registers; no clearing pass is needed. A stalled receiver
// holds the result register; the sender is stalled only when the held byte
// yields a result and the result register is full and stalled.
`default_nettype none

module websocket_frame_deframer_unit
  import wsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] stream_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      payload_byte_o,
  output logic            byte_valid_o,
  output logic            frame_end_o,
  output logic [3:0]      frame_opcode_o,
  output logic            final_fragment_o,
  output logic [2:0]      reserved_bits_o,
  output logic            closing_o
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       has_result;
  logic       out_free;
  logic       fire;
  logic       load;
  result_t    step_result;
  result_t    out_result;

  // The held byte moves on unless its result would find the output register busy.
  assign fire = held_valid && (!has_result || out_free);
  assign load = fire && has_result;

  wsd_input_stage u_input (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .fire_i        (fire),
    .held_valid_o  (held_valid),
    .held_byte_o   (held_byte)
  );

  wsd_frame_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .byte_i       (held_byte),
    .has_result_o (has_result),
    .result_o     (step_result)
  );

  wsd_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign payload_byte_o   = out_result.payload_byte;
  assign byte_valid_o     = out_result.byte_valid;
  assign frame_end_o      = out_result.frame_end;
  assign frame_opcode_o   = out_result.frame_opcode;
  assign final_fragment_o = out_result.final_fragment;
  assign reserved_bits_o  = out_result.reserved_bits;
  assign closing_o        = out_result.closing;

  // Once a close result is taken, no further result may follow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && closing_o) |=> !out_valid_o)
    else $error("result delivered after close frame");

  // A result without a payload byte is a frame end and carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (frame_end_o && (payload_byte_o == 8'h00)))
    else $error("empty result is not a clean frame end");

  // The sender is stalled only while the input register holds a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> held_valid)
    else $error("input stalled with empty input register");

  // A result is loaded only into a register that is empty or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_o) |-> !out_stall_i)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the WebSocket frame deframer with random flow control.
module tb
  import wsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no transaction on either channel before the run is abandoned.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Cycles allowed after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Least number of stream bytes driven by the random frame test.
  localparam int unsigned RANDOM_BYTES = 1500;

  // How a frame announces its payload length.
  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] stream_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       byte_valid_o;
  logic       frame_end_o;
  logic [3:0] frame_opcode_o;
  logic       final_fragment_o;
  logic [2:0] reserved_bits_o;
  logic       closing_o;

  websocket_frame_deframer_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_byte_o   (payload_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_end_o      (frame_end_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .reserved_bits_o  (reserved_bits_o),
    .closing_o        (closing_o)
  );

  // Free-running clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Parser state as the testbench expects it to be.
  phase_e      parse_phase = PH_HDR0;
  logic [2:0]  parse_count = '0;
  logic        frame_fin = 1'b0;
  logic [2:0]  frame_rsv = '0;
  logic [3:0]  frame_op = '0;
  logic        frame_masked = 1'b0;
  logic [63:0] bytes_left = '0;
  logic [31:0] frame_key = '0;
  logic [1:0]  key_pos = '0;

  // Unmasked results still to come out of the block, oldest first.
  result_t     pending_results[$];
  result_t     due_result;

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  logic        tx_gaps_on = 1'b1;
  logic        rx_stalls_on = 1'b1;
  int unsigned stall_run = 0;
  int unsigned stall_roll;

  // Queue one expected result; the end of a frame returns the parser to the header.
  task automatic queue_result(input logic [7:0] data, input logic carried, input logic last);
    result_t r;
    r.payload_byte   = data;
    r.byte_valid     = carried;
    r.frame_end      = last;
    r.frame_opcode   = frame_op;
    r.final_fragment = frame_fin;
    r.reserved_bits  = frame_rsv;
    r.closing        = last && (frame_op == OPCODE_CLOSE);
    pending_results.push_back(r);
    if (last) begin
      parse_phase = r.closing ? PH_DEAD : PH_HDR0;
      parse_count = '0;
    end
  endtask

  // Move to the payload, or finish the frame at once when it is empty.
  task automatic start_payload();
    key_pos = '0;
    parse_count = '0;
    if (bytes_left == 0) begin
      queue_result(8'h00, 1'b0, 1'b1);
    end else begin
      parse_phase = PH_PAYLOAD;
    end
  endtask

  // The length is complete: clamp it, then expect a mask key or the payload.
  task automatic length_complete();
    if (bytes_left > LENGTH_MAX) begin
      bytes_left = LENGTH_MAX;
    end
    parse_count = '0;
    if (frame_masked) begin
      parse_phase = PH_MASK;
    end else begin
      start_payload();
    end
  endtask

  // Advance the expected parser state by one accepted stream byte.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    case (parse_phase)
      PH_DEAD: begin
      end
      PH_HDR1: begin
        frame_masked = b[7];
        bytes_left = '0;
        frame_key = '0;
        parse_count = '0;
        if (b[6:0] == LEN7_EXT16) begin
          parse_phase = PH_LEN16;
        end else if (b[6:0] == LEN7_EXT64) begin
          parse_phase = PH_LEN64;
        end else begin
          bytes_left = 64'(b[6:0]);
          length_complete();
        end
      end
      PH_LEN16, PH_LEN64: begin
        bytes_left = {bytes_left[55:0], b};
        parse_count = parse_count + 3'd1;
        if ((parse_phase == PH_LEN16 && parse_count == LEN16_BYTES) ||
            (parse_phase == PH_LEN64 && parse_count == LEN64_WRAP)) begin
          length_complete();
        end
      end
      PH_MASK: begin
        frame_key = {frame_key[23:0], b};
        parse_count = parse_count + 3'd1;
        if (parse_count >= MASK_KEY_BYTES) begin
          start_payload();
        end
      end
      PH_PAYLOAD: begin
        key_byte = frame_masked ? frame_key[8 * (3 - key_pos) +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        if (bytes_left != 0) begin
          bytes_left = bytes_left - 64'd1;
        end
        queue_result(b ^ key_byte, 1'b1, bytes_left == 0);
      end
      default: begin
        frame_fin = b[7];
        frame_rsv = b[6:4];
        frame_op = b[3:0];
        parse_phase = PH_HDR1;
        parse_count = '0;
      end
    endcase
  endtask

  // Offer one stream byte after an optional gap and hold it until it is taken.
  task automatic push_byte(input logic [7:0] b);
    int unsigned roll;
    int unsigned gap;
    gap = 0;
    if (tx_gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
        gap = $urandom_range(6, 24);
      end else if (roll >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // Send a whole frame: header, length in the chosen form, key when masked and random payload.
  task automatic send_frame(input logic [7:0] hdr, input logic masked,
                            input int unsigned len, input len_form_e form);
    logic [31:0] key;
    logic [63:0] len_bytes;
    key = $urandom;
    len_bytes = 64'(len);
    push_byte(hdr);
    case (form)
      LEN_SHORT: begin
        push_byte({masked, len_bytes[6:0]});
      end
      LEN_EXT16: begin
        push_byte({masked, LEN7_EXT16});
        push_byte(len_bytes[15:8]);
        push_byte(len_bytes[7:0]);
      end
      default: begin
        push_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) begin
          push_byte(len_bytes[8 * i +: 8]);
        end
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) begin
        push_byte(key[8 * i +: 8]);
      end
    end
    for (int unsigned n = 0; n < len; n++) begin
      push_byte(8'($urandom));
    end
  endtask

  // Empty frames end on the header or on the last mask key byte.
  task automatic test_empty_frames();
    send_frame(8'h81, 1'b0, 0, LEN_SHORT);
    send_frame(8'h70, 1'b1, 0, LEN_SHORT);
  endtask

  // Masked payload wraps round the key; all header bits set together.
  task automatic test_masking();
    send_frame(8'hFF, 1'b1, 5, LEN_SHORT);
  endtask

  // Non-minimal 16-bit and 64-bit lengths, the latter with a mask.
  task automatic test_extended_lengths();
    send_frame(8'h02, 1'b0, 3, LEN_EXT16);
    send_frame(8'h89, 1'b1, 2, LEN_EXT64);
  endtask

  // Well-formed frames with random headers, lengths, keys and payloads.
  task automatic test_random_frames();
    int unsigned first;
    int unsigned roll;
    int unsigned len;
    logic [3:0]  op;
    len_form_e   form;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      // Now and then a frame runs without gaps, without stalls, or without both.
      tx_gaps_on = ($urandom_range(0, 5) != 0);
      rx_stalls_on = ($urandom_range(0, 5) != 0);
      do op = 4'($urandom); while (op == OPCODE_CLOSE);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        len = 0;
      end else if (roll < 65) begin
        len = $urandom_range(1, 12);
      end else if (roll < 90) begin
        len = $urandom_range(13, 125);
      end else begin
        len = $urandom_range(126, 300);
      end
      roll = $urandom_range(0, 99);
      if (len >= 126) begin
        form = (roll < 70) ? LEN_EXT16 : LEN_EXT64;
      end else if (roll < 70) begin
        form = LEN_SHORT;
      end else if (roll < 85) begin
        form = LEN_EXT16;
      end else begin
        form = LEN_EXT64;
      end
      send_frame({1'($urandom), 3'($urandom), op}, 1'($urandom), len, form);
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // A finished close frame stops the parser; later bytes give nothing.
  task automatic test_close_frame();
    send_frame({1'b1, 3'b000, OPCODE_CLOSE}, 1'b1, 3, LEN_SHORT);
    for (int i = 0; i < 20; i++) begin
      push_byte(8'($urandom));
    end
  endtask

  // Compare one field of a result transaction.
  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result expected none, got payload 0x%0h end %0b", $time,
                 payload_byte_o, frame_end_o);
        mismatches++;
      end else begin
        due_result = pending_results.pop_front();
        check_field("payload_byte", due_result.payload_byte, payload_byte_o);
        check_field("byte_valid", 8'(due_result.byte_valid), 8'(byte_valid_o));
        check_field("frame_end", 8'(due_result.frame_end), 8'(frame_end_o));
        check_field("frame_opcode", 8'(due_result.frame_opcode), 8'(frame_opcode_o));
        check_field("final_fragment", 8'(due_result.final_fragment), 8'(final_fragment_o));
        check_field("reserved_bits", 8'(due_result.reserved_bits), 8'(reserved_bits_o));
        check_field("closing", 8'(due_result.closing), 8'(closing_o));
      end
    end
  end

  // Receiver stalls: mostly free, short bursts, occasionally a long hold.
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (!rx_stalls_on || stall_roll < 65) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall_i <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run <= $urandom_range(8, 30);
      end
    end
  end

  // Watchdog: abandon the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Test sequence; the close frame comes last as it ends all parsing.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_frames();
    test_masking();
    test_extended_lengths();
    test_random_frames();
    test_close_frame();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wsd_pkg.sv
rtl/wsd_input_stage.sv
rtl/wsd_frame_fsm.sv
rtl/wsd_output_stage.sv
rtl/websocket_frame_deframer_unit.sv
verif/tb.sv
